// ===== hdl/mfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types, register indexes and the control program of the multilevel
// feedback queue finish-time scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int unsigned TIME_BITS  = 20;
    localparam int unsigned LEVEL_BITS = 3;
    localparam int unsigned QUANT_BITS = 16;
    localparam int unsigned CFG_BITS   = 16;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned OUT_DATA_BITS = 32;
    localparam int unsigned NUM_QUANTA = 4;
    localparam logic [TIME_BITS-1:0] TIME_MAX = 20'hFFFFF;

    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_LEVELS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUANTUM0   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUANTUM1   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUANTUM2   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUANTUM3   = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_READ,
        OP_RR,
        OP_REWIND,
        OP_FCFS,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_LEVELS,
        C_MORE_ENTRIES,
        C_MORE_LEVELS,
        C_LAST_ENTRY
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step S_IDLE     = 4'd0;
    localparam t_step S_INIT     = 4'd1;
    localparam t_step S_RR_RD    = 4'd2;
    localparam t_step S_RR_EX    = 4'd3;
    localparam t_step S_RR_NEXT  = 4'd4;
    localparam t_step S_FC_RD    = 4'd5;
    localparam t_step S_FC_EX    = 4'd6;
    localparam t_step S_OUT_INIT = 4'd7;
    localparam t_step S_OUT_RD   = 4'd8;
    localparam t_step S_OUT_EMIT = 4'd9;
    localparam t_step S_OUT_NEXT = 4'd10;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_cw;

    typedef struct packed {
        logic busy;
        logic no_levels;
        logic last_entry;
        logic last_level;
    } t_stat;

    function automatic t_cw mfq_prog(input t_step pc);
        t_cw cw;
        case (pc)
            S_IDLE:     cw = '{op: OP_LOAD,   cond: C_ALWAYS,       target: S_INIT};
            S_INIT:     cw = '{op: OP_INIT,   cond: C_NO_LEVELS,    target: S_FC_RD};
            S_RR_RD:    cw = '{op: OP_READ,   cond: C_NEVER,        target: S_IDLE};
            S_RR_EX:    cw = '{op: OP_RR,     cond: C_MORE_ENTRIES, target: S_RR_RD};
            S_RR_NEXT:  cw = '{op: OP_REWIND, cond: C_MORE_LEVELS,  target: S_RR_RD};
            S_FC_RD:    cw = '{op: OP_READ,   cond: C_NEVER,        target: S_IDLE};
            S_FC_EX:    cw = '{op: OP_FCFS,   cond: C_MORE_ENTRIES, target: S_FC_RD};
            S_OUT_INIT: cw = '{op: OP_REWIND, cond: C_NEVER,        target: S_IDLE};
            S_OUT_RD:   cw = '{op: OP_READ,   cond: C_NEVER,        target: S_IDLE};
            S_OUT_EMIT: cw = '{op: OP_EMIT,   cond: C_LAST_ENTRY,   target: S_IDLE};
            S_OUT_NEXT: cw = '{op: OP_NOP,    cond: C_ALWAYS,       target: S_OUT_RD};
            default:    cw = '{op: OP_NOP,    cond: C_ALWAYS,       target: S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ===== hdl/mfq_seq.sv =====
// ----------------------------------------------------------------------------
// mfq_seq
// Step counter and program table; issues one control word per step and
// follows conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mfq_seq
    import mfq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_op   o_op
);

    t_step r_pc;
    t_step n_pc;
    t_cw   w_cw;
    logic  w_take;

    assign w_cw = mfq_prog(r_pc);
    assign o_op = w_cw.op;

    always_comb begin
        case (w_cw.cond)
            C_NEVER:        w_take = 1'b0;
            C_ALWAYS:       w_take = 1'b1;
            C_NO_LEVELS:    w_take = i_stat.no_levels;
            C_MORE_ENTRIES: w_take = !i_stat.last_entry;
            C_MORE_LEVELS:  w_take = !i_stat.last_level;
            C_LAST_ENTRY:   w_take = i_stat.last_entry;
            default:        w_take = 1'b0;
        endcase
        if (i_stat.busy) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_cw.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== hdl/mlfq_finish_time_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// mlfq_finish_time_scheduler_core
// Multilevel feedback queue finish-time scheduler with a microcoded control.
// ----------------------------------------------------------------------------
// Usage:
//   Stream burst times in on s_axis (one item per cycle while idle); tlast
//   marks the final process of a set. Bursts beyond MAX_PROCESSES are dropped.
//   Configuration (level count, four quanta) is written through i_cfg_* while
//   the block is idle.
//   After the last item the sequencer runs each time-sliced level as one pass
//   over the held processes, then a run-to-completion pass. Each entry visit
//   is a memory read step then an update step, and each level adds a rewind
//   step. Results then leave on m_axis in index order, each through the read
//   and emit steps on the result memory; tlast flags the final process.
//   s_axis_tready is low from the last item until the final result is
//   registered. A stall on m_axis holds the emit step; the output register
//   keeps its item until taken.
//   Reset clears the process count, the sequencer and the output register and
//   loads the default configuration; the process memories need no clearing.
// ----------------------------------------------------------------------------
module mlfq_finish_time_scheduler_core
    import mfq_pkg::*;
#(
    parameter int unsigned MAX_PROCESSES = 16,
    parameter int unsigned MAX_RR_LEVELS = 4,
    parameter int unsigned BURST_BITS    = 16
)(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [CFG_BITS-1:0]            i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // burst_time
    input  logic [((BURST_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // process_index[3:0], finish_time[23:4], finish_level[26:24]
    output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int unsigned IW = $clog2(MAX_PROCESSES);
    localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned AW = (BURST_BITS > QUANT_BITS) ? BURST_BITS : QUANT_BITS;
    localparam int unsigned SW = ((AW > TIME_BITS) ? AW : TIME_BITS) + 1;
    localparam int unsigned RESW = TIME_BITS + LEVEL_BITS;

    t_op   w_op;
    t_stat w_stat;

    logic [LEVEL_BITS-1:0] r_num_levels;
    logic [QUANT_BITS-1:0] r_quantum [NUM_QUANTA];
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_j;
    logic [LEVEL_BITS-1:0] r_lv;
    logic [TIME_BITS-1:0]  r_clk;

    logic [BURST_BITS:0]   mem_rem [MAX_PROCESSES];
    logic [RESW-1:0]       mem_res [MAX_PROCESSES];
    logic [BURST_BITS:0]   r_rem_rd;
    logic [RESW-1:0]       r_res_rd;

    logic                  r_ov;
    logic [3:0]            r_o_index;
    logic [TIME_BITS-1:0]  r_o_time;
    logic [LEVEL_BITS-1:0] r_o_level;
    logic                  r_o_last;

    logic [LEVEL_BITS-1:0] w_levels;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_done;
    logic [BURST_BITS-1:0] w_rem;
    logic [QUANT_BITS-1:0] w_q;
    logic                  w_gt;
    logic [AW-1:0]         w_slice;
    logic [SW-1:0]         w_sum;
    logic [TIME_BITS-1:0]  w_clk_next;
    logic [IW-1:0]         w_addr;
    logic                  w_rem_we;
    logic [BURST_BITS:0]   w_rem_wdata;
    logic                  w_res_we;
    logic [RESW-1:0]       w_res_wdata;

    mfq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    assign w_levels = (r_num_levels > LEVEL_BITS'(MAX_RR_LEVELS))
                    ? LEVEL_BITS'(MAX_RR_LEVELS) : r_num_levels;

    assign s_axis_tready = (w_op == OP_LOAD);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ov || m_axis_tready;

    assign w_stat.busy       = ((w_op == OP_LOAD) && !(w_accept && s_axis_tlast))
                            || ((w_op == OP_EMIT) && !w_out_free);
    assign w_stat.no_levels  = (w_levels == '0);
    assign w_stat.last_entry = (CW'(r_j + 1'b1) == r_cnt);
    assign w_stat.last_level = (LEVEL_BITS'(r_lv + 1'b1) >= w_levels);

    assign w_done = r_rem_rd[BURST_BITS];
    assign w_rem  = r_rem_rd[BURST_BITS-1:0];
    assign w_q    = r_quantum[r_lv[1:0]];
    assign w_gt   = AW'(w_rem) > AW'(w_q);

    always_comb begin
        if ((w_op == OP_RR) && w_gt) begin
            w_slice = AW'(w_q);
        end else begin
            w_slice = AW'(w_rem);
        end
        w_sum = SW'(r_clk) + SW'(w_slice);
        if (w_sum > SW'(TIME_MAX)) begin
            w_clk_next = TIME_MAX;
        end else begin
            w_clk_next = w_sum[TIME_BITS-1:0];
        end
    end

    always_comb begin
        w_addr      = r_j[IW-1:0];
        w_rem_we    = 1'b0;
        w_rem_wdata = {1'b1, {BURST_BITS{1'b0}}};
        w_res_we    = 1'b0;
        w_res_wdata = {w_levels, w_clk_next};
        case (w_op)
            OP_LOAD: begin
                w_addr      = r_cnt[IW-1:0];
                w_rem_we    = w_accept && (r_cnt < CW'(MAX_PROCESSES));
                w_rem_wdata = {1'b0, s_axis_tdata[BURST_BITS-1:0]};
            end
            OP_RR: begin
                if (!w_done) begin
                    w_rem_we = 1'b1;
                    if (w_gt) begin
                        w_rem_wdata = {1'b0, BURST_BITS'(AW'(w_rem) - AW'(w_q))};
                    end else begin
                        w_res_we    = 1'b1;
                        w_res_wdata = {r_lv, w_clk_next};
                    end
                end
            end
            OP_FCFS: begin
                w_rem_we = !w_done;
                w_res_we = !w_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rem_we) begin
            mem_rem[w_addr] <= w_rem_wdata;
        end
        if (w_res_we) begin
            mem_res[w_addr] <= w_res_wdata;
        end
        if (w_op == OP_READ) begin
            r_rem_rd <= mem_rem[w_addr];
            r_res_rd <= mem_res[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= 3'd2;
            r_quantum[0] <= 16'd4;
            r_quantum[1] <= 16'd8;
            r_quantum[2] <= 16'd16;
            r_quantum[3] <= 16'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_LEVELS: r_num_levels <= i_cfg_data[LEVEL_BITS-1:0];
                REG_QUANTUM0:   r_quantum[0] <= i_cfg_data;
                REG_QUANTUM1:   r_quantum[1] <= i_cfg_data;
                REG_QUANTUM2:   r_quantum[2] <= i_cfg_data;
                REG_QUANTUM3:   r_quantum[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_j       <= '0;
            r_lv      <= '0;
            r_clk     <= '0;
            r_ov      <= 1'b0;
            r_o_index <= '0;
            r_o_time  <= '0;
            r_o_level <= '0;
            r_o_last  <= 1'b0;
        end else begin
            if ((w_op == OP_EMIT) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (w_op)
                OP_LOAD: begin
                    if (w_rem_we) begin
                        r_cnt <= CW'(r_cnt + 1'b1);
                    end
                end
                OP_INIT: begin
                    r_j   <= '0;
                    r_lv  <= '0;
                    r_clk <= '0;
                end
                OP_RR, OP_FCFS: begin
                    if (!w_done) begin
                        r_clk <= w_clk_next;
                    end
                    r_j <= CW'(r_j + 1'b1);
                end
                OP_REWIND: begin
                    r_j  <= '0;
                    r_lv <= LEVEL_BITS'(r_lv + 1'b1);
                end
                OP_EMIT: begin
                    if (w_out_free) begin
                        r_o_index <= 4'(r_j);
                        r_o_time  <= r_res_rd[TIME_BITS-1:0];
                        r_o_level <= r_res_rd[RESW-1:TIME_BITS];
                        r_o_last  <= w_stat.last_entry;
                        r_j       <= CW'(r_j + 1'b1);
                        if (w_stat.last_entry) begin
                            r_cnt <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-4-RESW){1'b0}}, r_o_level, r_o_time, r_o_index};
    assign m_axis_tlast  = r_o_last;

endmodule
